/* src/vialu_pkg.sv */
// Package: command codes, lane count and lane result record for the vector ALU.
`timescale 1ns / 1ps
`default_nettype none
package vialu_pkg;

   localparam int NUM_LANES  = 4;
   localparam int SLOT_WIDTH = 32;

   typedef enum logic [4:0] {
      CMD_PASS     = 5'd0,
      CMD_ZERO     = 5'd1,
      CMD_ONE      = 5'd2,
      CMD_SIGN     = 5'd3,
      CMD_ADD      = 5'd4,
      CMD_ADD_S    = 5'd5,
      CMD_SUB      = 5'd6,
      CMD_SUB_S    = 5'd7,
      CMD_MUL      = 5'd8,
      CMD_MUL_S    = 5'd9,
      CMD_DIV      = 5'd10,
      CMD_DIV_S    = 5'd11,
      CMD_SNAP     = 5'd12,
      CMD_SNAP_S   = 5'd13,
      CMD_NEG      = 5'd14,
      CMD_ABS      = 5'd15,
      CMD_MAX      = 5'd16,
      CMD_MIN      = 5'd17,
      CMD_CLAMP    = 5'd18,
      CMD_IS_ZERO  = 5'd19,
      CMD_IS_EQUAL = 5'd20
   } cmd_type;

   // one lane's registered answer, already sign-extended to the slot width
   typedef struct packed {
      logic [SLOT_WIDTH-1:0] res;
      logic                  dz;
      logic                  fz;
      logic                  fe;
      logic                  opz;
      logic                  ope;
   } lane_out_type;

endpackage
`default_nettype wire

/* src/vialu_if.sv */
// Request and response channel interfaces of the vector ALU.
`timescale 1ns / 1ps
`default_nettype none
interface vialu_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  cmd;
   logic [63:0] a_lanes01;
   logic [63:0] a_lanes23;
   logic [63:0] b_lanes01;
   logic [63:0] b_lanes23;
   logic [63:0] c_lanes01;
   logic [63:0] c_lanes23;
   logic signed [31:0] scalar;

   modport source (output valid, cmd, a_lanes01, a_lanes23, b_lanes01, b_lanes23,
                   c_lanes01, c_lanes23, scalar, input ready);
   modport sink   (input valid, cmd, a_lanes01, a_lanes23, b_lanes01, b_lanes23,
                   c_lanes01, c_lanes23, scalar, output ready);
endinterface

interface vialu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] r0;
   logic signed [31:0] r1;
   logic signed [31:0] r2;
   logic signed [31:0] r3;
   logic               flag;
   logic               div_zero;

   modport source (output valid, r0, r1, r2, r3, flag, div_zero, input ready);
   modport sink   (input valid, r0, r1, r2, r3, flag, div_zero, output ready);
endinterface
`default_nettype wire

/* src/vialu_lane.sv */
// One ALU lane: decode and multiply stage, pipelined restoring divider, sign fix and snap.
`timescale 1ns / 1ps
`default_nettype none
module vialu_lane
   import vialu_pkg::*;
#(
   parameter int LANE_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic [4:0]            cmd,
   input  wire logic [SLOT_WIDTH-1:0] a_slot,
   input  wire logic [SLOT_WIDTH-1:0] b_slot,
   input  wire logic [SLOT_WIDTH-1:0] c_slot,
   input  wire logic [SLOT_WIDTH-1:0] s_slot,
   output lane_out_type               lane_out
);

   localparam int W = LANE_WIDTH;

   typedef struct packed {
      logic [W-1:0] res;
      logic [W-1:0] y;
      logic         negq;
      logic         yz;
      logic         is_div;
      logic         is_snap;
      logic         fz;
      logic         fe;
      logic         opz;
      logic         ope;
   } carry_type;

   // decode stage
   logic signed [W-1:0] x, y, b, c;
   logic [W-1:0]        v, prod, ax, ay;
   logic                use_s;
   cmd_type             op;
   carry_type           car0_in;

   always_comb begin
      op    = cmd_type'(cmd);
      x     = a_slot[W-1:0];
      b     = b_slot[W-1:0];
      c     = c_slot[W-1:0];
      use_s = (cmd >= CMD_ADD_S) && (cmd <= CMD_SNAP_S) && cmd[0];
      y     = use_s ? s_slot[W-1:0] : b;
      prod  = x * y;
      ax    = x[W-1] ? -x : x;
      ay    = y[W-1] ? -y : y;
      case (op)
         CMD_PASS:               v = x;
         CMD_ZERO:               v = '0;
         CMD_ONE:                v = W'(1);
         CMD_SIGN:               v = (x > 0) ? W'(1) : (x < 0) ? '1 : '0;
         CMD_ADD, CMD_ADD_S:     v = x + y;
         CMD_SUB, CMD_SUB_S:     v = x - y;
         CMD_MUL, CMD_MUL_S:     v = prod;
         CMD_NEG:                v = -x;
         CMD_ABS:                v = x[W-1] ? -x : x;
         CMD_MAX:                v = (x > y) ? x : y;
         CMD_MIN:                v = (x < y) ? x : y;
         CMD_CLAMP:              v = (x < b) ? b : (x > c) ? c : x;
         default:                v = '0;
      endcase
      car0_in.res     = v;
      car0_in.y       = y;
      car0_in.negq    = x[W-1] ^ y[W-1];
      car0_in.yz      = (y == '0);
      car0_in.is_div  = (op == CMD_DIV) || (op == CMD_DIV_S);
      car0_in.is_snap = (op == CMD_SNAP) || (op == CMD_SNAP_S);
      car0_in.fz      = (x == '0);
      car0_in.fe      = (x == b);
      car0_in.opz     = (op == CMD_IS_ZERO);
      car0_in.ope     = (op == CMD_IS_EQUAL);
   end

   // divider pipeline, stage 0 holds the decoded operands
   carry_type    car_ff [W+1];
   logic [W-1:0] rem_ff [W+1];
   logic [W-1:0] quo_ff [W+1];
   logic [W-1:0] dvs_ff [W+1];

   always_ff @(posedge clock) begin
      if (en) begin
         car_ff[0] <= car0_in;
         rem_ff[0] <= '0;
         quo_ff[0] <= ax;
         dvs_ff[0] <= ay;
      end
   end

   for (genvar k = 0; k < W; k++) begin : g_div
      logic [W:0]   t;
      logic [W:0]   diff;
      logic         ge;
      logic [W-1:0] rem_in, quo_in;

      always_comb begin
         t      = {rem_ff[k], quo_ff[k][W-1]};
         diff   = t - {1'b0, dvs_ff[k]};
         ge     = (t >= {1'b0, dvs_ff[k]});
         rem_in = ge ? diff[W-1:0] : t[W-1:0];
         quo_in = {quo_ff[k][W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            car_ff[k+1] <= car_ff[k];
            rem_ff[k+1] <= rem_in;
            quo_ff[k+1] <= quo_in;
            dvs_ff[k+1] <= dvs_ff[k];
         end
      end
   end

   // quotient sign fix
   carry_type    carq_ff;
   logic [W-1:0] q_ff, q_in;

   assign q_in = car_ff[W].negq ? -quo_ff[W] : quo_ff[W];

   always_ff @(posedge clock) begin
      if (en) begin
         carq_ff <= car_ff[W];
         q_ff    <= q_in;
      end
   end

   // result select, snap multiply
   logic [W-1:0]        snapv;
   logic signed [W-1:0] fin;
   lane_out_type        out_in, out_ff;

   always_comb begin
      snapv = q_ff * carq_ff.y;
      if (carq_ff.is_div) begin
         fin = carq_ff.yz ? '1 : q_ff;
      end else if (carq_ff.is_snap) begin
         fin = carq_ff.yz ? '0 : snapv;
      end else begin
         fin = carq_ff.res;
      end
      out_in.res = SLOT_WIDTH'(fin);
      out_in.dz  = (carq_ff.is_div | carq_ff.is_snap) & carq_ff.yz;
      out_in.fz  = carq_ff.fz;
      out_in.fe  = carq_ff.fe;
      out_in.opz = carq_ff.opz;
      out_in.ope = carq_ff.ope;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign lane_out = out_ff;

endmodule
`default_nettype wire

/* src/vialu_merge.sv */
// Merge of the four lane answers into result lanes, compare flag and divide-by-zero flag.
`timescale 1ns / 1ps
`default_nettype none
module vialu_merge
   import vialu_pkg::*;
(
   input  wire lane_out_type            lanes [NUM_LANES],
   output logic signed [SLOT_WIDTH-1:0] res   [NUM_LANES],
   output logic                         flag,
   output logic                         div_zero
);

   logic all_z, all_e, any_dz;

   always_comb begin
      all_z  = 1'b1;
      all_e  = 1'b1;
      any_dz = 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
         all_z  = all_z & lanes[i].fz;
         all_e  = all_e & lanes[i].fe;
         any_dz = any_dz | lanes[i].dz;
         res[i] = lanes[i].res;
      end
      flag     = (lanes[0].opz & all_z) | (lanes[0].ope & all_e);
      div_zero = any_dz;
   end

endmodule
`default_nettype wire

/* src/vec4_int_alu_core.sv */
// Top level of the four-lane signed integer vector ALU.
// Four identical lanes each take one LANE_WIDTH-bit element of a, b and c plus
// the scalar, and one merge stage forms r0..r3, flag and div_zero. One item is
// taken every cycle unless the pipeline is held; the divider in every lane
// resolves one quotient bit per stage. When the result register is held, the
// whole pipeline holds with it.
`timescale 1ns / 1ps
`default_nettype none
module vec4_int_alu_core
   import vialu_pkg::*;
#(
   parameter int LANE_WIDTH = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   vialu_req_if.sink   req,
   vialu_rsp_if.source rsp
);

   localparam int DEPTH = LANE_WIDTH + 3;

   logic [DEPTH-1:0] vld_ff, vld_in;
   logic             en;

   assign en     = ~vld_ff[DEPTH-1] | rsp.ready;
   assign vld_in = {vld_ff[DEPTH-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   logic [SLOT_WIDTH-1:0] a_slot [NUM_LANES];
   logic [SLOT_WIDTH-1:0] b_slot [NUM_LANES];
   logic [SLOT_WIDTH-1:0] c_slot [NUM_LANES];

   always_comb begin
      a_slot[0] = req.a_lanes01[31:0];
      a_slot[1] = req.a_lanes01[63:32];
      a_slot[2] = req.a_lanes23[31:0];
      a_slot[3] = req.a_lanes23[63:32];
      b_slot[0] = req.b_lanes01[31:0];
      b_slot[1] = req.b_lanes01[63:32];
      b_slot[2] = req.b_lanes23[31:0];
      b_slot[3] = req.b_lanes23[63:32];
      c_slot[0] = req.c_lanes01[31:0];
      c_slot[1] = req.c_lanes01[63:32];
      c_slot[2] = req.c_lanes23[31:0];
      c_slot[3] = req.c_lanes23[63:32];
   end

   lane_out_type lanes [NUM_LANES];

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      vialu_lane #(
         .LANE_WIDTH (LANE_WIDTH)
      ) u_lane (
         .clock    (clock),
         .en       (en),
         .cmd      (req.cmd),
         .a_slot   (a_slot[i]),
         .b_slot   (b_slot[i]),
         .c_slot   (c_slot[i]),
         .s_slot   (req.scalar),
         .lane_out (lanes[i])
      );
   end

   logic signed [SLOT_WIDTH-1:0] res [NUM_LANES];

   vialu_merge u_merge (
      .lanes    (lanes),
      .res      (res),
      .flag     (rsp.flag),
      .div_zero (rsp.div_zero)
   );

   assign req.ready = en;
   assign rsp.valid = vld_ff[DEPTH-1];
   assign rsp.r0    = res[0];
   assign rsp.r1    = res[1];
   assign rsp.r2    = res[2];
   assign rsp.r3    = res[3];

endmodule
`default_nettype wire
